// ===== design/pfqm_pkg.sv =====
// Shared constants for the power floor-quotient modulo block.
package pfqm_pkg;

  // Width of every port field
  localparam int FIELD_W = 32;

  // Default arithmetic width of the datapath
  localparam int WIDTH_DEFAULT = 32;

endpackage : pfqm_pkg

// ===== design/power_floor_quotient_mod_core.sv =====
// Top level: floor(x^y / k) mod p by square-and-multiply on a shared multiply/divide unit.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+------------------------------------------
//   in      | request   | in_valid_i / in_stall_o   | base_value_i, exponent_i, divisor_i,
//           |           |                           | modulus_i
//   out     | result    | out_valid_o / out_stall_i | quotient_mod_o, bad_operand_o
//
// Sequence: a step is one multiply, a restoring division and a writeback; setup takes 3 steps
//   and each pair product 6. After a scan down to the top set exponent bit, a request runs
//   one squaring pair product per lower exponent bit and one more per set bit among them;
//   a zero divisor or modulus, or a zero exponent, skips the steps.
// Reset clears the sequencer and the output valid; the datapath registers are not reset.
// A request is taken once the last result is in the output register; a stall blocks only that.
module power_floor_quotient_mod_core #(
  parameter int WIDTH = pfqm_pkg::WIDTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pfqm_pkg::FIELD_W-1:0] base_value_i,
  input  logic [pfqm_pkg::FIELD_W-1:0] exponent_i,
  input  logic [pfqm_pkg::FIELD_W-1:0] divisor_i,
  input  logic [pfqm_pkg::FIELD_W-1:0] modulus_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pfqm_pkg::FIELD_W-1:0] quotient_mod_o,
  output logic                         bad_operand_o
);

  localparam int DW = 2 * WIDTH;
  localparam int IW = $clog2(WIDTH);
  localparam int FW = pfqm_pkg::FIELD_W;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [IW-1:0]    idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_DIV,
    ST_WB,
    ST_SCAN,
    ST_FIN
  } state_e;

  // Arithmetic steps; each is one multiply followed by one division
  typedef enum logic [3:0] {
    SP_KP,   // k mod p
    SP_XK,   // x / k and x mod k
    SP_XKP,  // (x / k) mod p
    SP_T0A,  // (k mod p) * u.q mod p
    SP_T0B,  // previous * v.q mod p
    SP_T1,   // u.r * v.q mod p
    SP_T2,   // v.r * u.q mod p
    SP_RR,   // u.r * v.r divided by k
    SP_T3    // floor(u.r * v.r / k) mod p
  } step_e;

  // Modular add of two values already below the modulus
  function automatic word_t mod_add(word_t a, word_t b, word_t m);
    logic [WIDTH:0] s;
    logic [WIDTH:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = s - {1'b0, m};
    if (s >= {1'b0, m}) begin
      return t[WIDTH-1:0];
    end
    return s[WIDTH-1:0];
  endfunction

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   out_valid_q, out_valid_d;
  word_t  quot_out_q, quot_out_d;
  logic   bad_out_q, bad_out_d;

  word_t  x_q, x_d, y_q, y_d, k_q, k_d, p_q, p_d;
  word_t  kp_q, kp_d, bq_q, bq_d, br_q, br_d, aq_q, aq_d, ar_q, ar_d;
  word_t  tmp_q, tmp_d, sum_q, sum_d, nr_q, nr_d, res_q, res_d;
  logic   err_q, err_d, sel_q, sel_d;
  idx_t   idx_q, idx_d, cnt_q, cnt_d;
  word_t  rem_q, rem_d, lo_q, lo_d, d_q, d_d;

  word_t          mul_a, mul_b, div_d, vq, vr, madd;
  logic [DW-1:0]  prod;
  logic [WIDTH:0] rem_ext, rem_diff;
  logic           rem_ge, out_free;

  // Second operand of a pair product: base or accumulator
  assign vq = sel_q ? bq_q : aq_q;
  assign vr = sel_q ? br_q : ar_q;

  // Operand and divisor selection for the shared unit
  always_comb begin
    mul_a = x_q;
    mul_b = WIDTH'(1);
    div_d = p_q;
    case (step_q)
      SP_KP:  begin mul_a = k_q;   mul_b = WIDTH'(1); div_d = p_q; end
      SP_XK:  begin mul_a = x_q;   mul_b = WIDTH'(1); div_d = k_q; end
      SP_XKP: begin mul_a = tmp_q; mul_b = WIDTH'(1); div_d = p_q; end
      SP_T0A: begin mul_a = kp_q;  mul_b = aq_q;      div_d = p_q; end
      SP_T0B: begin mul_a = tmp_q; mul_b = vq;        div_d = p_q; end
      SP_T1:  begin mul_a = ar_q;  mul_b = vq;        div_d = p_q; end
      SP_T2:  begin mul_a = vr;    mul_b = aq_q;      div_d = p_q; end
      SP_RR:  begin mul_a = ar_q;  mul_b = vr;        div_d = k_q; end
      SP_T3:  begin mul_a = tmp_q; mul_b = WIDTH'(1); div_d = p_q; end
      default: begin mul_a = x_q;  mul_b = WIDTH'(1); div_d = p_q; end
    endcase
  end

  // Shared multiplier, restoring divide step and modular adder
  assign prod     = DW'(mul_a) * DW'(mul_b);
  assign rem_ext  = {rem_q, lo_q[WIDTH-1]};
  assign rem_diff = rem_ext - {1'b0, d_q};
  assign rem_ge   = (rem_ext >= {1'b0, d_q});
  assign madd     = mod_add(sum_q, rem_q, p_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    quot_out_d  = quot_out_q;
    bad_out_d   = bad_out_q;
    x_d   = x_q;   y_d   = y_q;   k_d   = k_q;   p_d   = p_q;
    kp_d  = kp_q;  bq_d  = bq_q;  br_d  = br_q;  aq_d  = aq_q;  ar_d = ar_q;
    tmp_d = tmp_q; sum_d = sum_q; nr_d  = nr_q;  res_d = res_q; err_d = err_q;
    sel_d = sel_q; idx_d = idx_q; cnt_d = cnt_q;
    rem_d = rem_q; lo_d  = lo_q;  d_d   = d_q;

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d     = base_value_i[WIDTH-1:0];
          y_d     = exponent_i[WIDTH-1:0];
          k_d     = divisor_i[WIDTH-1:0];
          p_d     = modulus_i[WIDTH-1:0];
          state_d = ST_START;
        end
      end

      // special cases, else start the setup steps
      ST_START: begin
        if (k_q == '0 || p_q == '0) begin
          res_d   = '0;
          err_d   = 1'b1;
          state_d = ST_FIN;
        end else if (y_q == '0) begin
          res_d   = (k_q == WIDTH'(1) && p_q != WIDTH'(1)) ? WIDTH'(1) : '0;
          err_d   = 1'b0;
          state_d = ST_FIN;
        end else begin
          err_d   = 1'b0;
          step_d  = SP_KP;
          state_d = ST_MUL;
        end
      end

      // product loads the dividend
      ST_MUL: begin
        rem_d   = prod[DW-1:WIDTH];
        lo_d    = prod[WIDTH-1:0];
        d_d     = div_d;
        cnt_d   = idx_t'(WIDTH - 1);
        state_d = ST_DIV;
      end

      // one quotient bit per cycle; quotient shifts into lo
      ST_DIV: begin
        rem_d = rem_ge ? rem_diff[WIDTH-1:0] : rem_ext[WIDTH-1:0];
        lo_d  = {lo_q[WIDTH-2:0], rem_ge};
        if (cnt_q == '0) begin
          state_d = ST_WB;
        end else begin
          cnt_d = cnt_q - idx_t'(1);
        end
      end

      // take the remainder / quotient and pick the next step
      ST_WB: begin
        state_d = ST_MUL;
        case (step_q)
          SP_KP: begin
            kp_d   = rem_q;
            step_d = SP_XK;
          end
          SP_XK: begin
            br_d   = rem_q;
            tmp_d  = lo_q;
            step_d = SP_XKP;
          end
          SP_XKP: begin
            bq_d    = rem_q;
            aq_d    = rem_q;
            ar_d    = br_q;
            idx_d   = idx_t'(WIDTH - 1);
            state_d = ST_SCAN;
          end
          SP_T0A: begin
            tmp_d  = rem_q;
            step_d = SP_T0B;
          end
          SP_T0B: begin
            sum_d  = rem_q;
            step_d = SP_T1;
          end
          SP_T1: begin
            sum_d  = madd;
            step_d = SP_T2;
          end
          SP_T2: begin
            sum_d  = madd;
            step_d = SP_RR;
          end
          SP_RR: begin
            nr_d   = rem_q;
            tmp_d  = lo_q;
            step_d = SP_T3;
          end
          SP_T3: begin
            aq_d   = madd;
            ar_d   = nr_q;
            step_d = SP_T0A;
            if (!sel_q && y_q[idx_q]) begin
              sel_d = 1'b1;
            end else if (idx_q == '0) begin
              res_d   = madd;
              state_d = ST_FIN;
            end else begin
              sel_d = 1'b0;
              idx_d = idx_q - idx_t'(1);
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      // walk down to the top set exponent bit
      ST_SCAN: begin
        if (y_q[idx_q]) begin
          if (idx_q == '0) begin
            res_d   = aq_q;
            state_d = ST_FIN;
          end else begin
            idx_d   = idx_q - idx_t'(1);
            sel_d   = 1'b0;
            step_d  = SP_T0A;
            state_d = ST_MUL;
          end
        end else begin
          idx_d = idx_q - idx_t'(1);
        end
      end

      // hand over to the output register
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          quot_out_d  = res_q;
          bad_out_d   = err_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      quot_out_q  <= '0;
      bad_out_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      quot_out_q  <= quot_out_d;
      bad_out_q   <= bad_out_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    x_q    <= x_d;   y_q   <= y_d;   k_q   <= k_d;   p_q  <= p_d;
    kp_q   <= kp_d;  bq_q  <= bq_d;  br_q  <= br_d;  aq_q <= aq_d;  ar_q <= ar_d;
    tmp_q  <= tmp_d; sum_q <= sum_d; nr_q  <= nr_d;  res_q <= res_d; err_q <= err_d;
    sel_q  <= sel_d; idx_q <= idx_d; cnt_q <= cnt_d;
    rem_q  <= rem_d; lo_q  <= lo_d;  d_q   <= d_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign quotient_mod_o = FW'(quot_out_q);
  assign bad_operand_o  = bad_out_q;

  // Partial remainder stays below the divisor while dividing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < d_q))
    else $error("partial remainder not below divisor");

  // Accumulator pair is reduced while scanning exponent bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((aq_q < p_q) && (ar_q < k_q)))
    else $error("accumulator pair out of range");

  // Writeback only follows a completed division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB) |-> ($past(state_q) == ST_DIV))
    else $error("writeback without division");

  // Error results carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_operand_o) |-> (quotient_mod_o == '0))
    else $error("error result with non-zero value");

endmodule : power_floor_quotient_mod_core

// ===== sim/power_floor_quotient_mod_core_tb.sv =====
// Self-checking testbench for power_floor_quotient_mod_core: floor(x^y / k) mod p per request.
module power_floor_quotient_mod_core_tb;

  localparam int          ARITH_W     = pfqm_pkg::WIDTH_DEFAULT;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
  localparam longint      CYCLE_LIMIT = 20_000_000;
  localparam int          SHOWN_MAX   = 10;

  typedef logic [pfqm_pkg::FIELD_W-1:0] field_t;

  typedef struct packed {
    field_t quot;
    logic   bad;
  } outcome_t;

  // Predicts each result and compares the block's results in order
  class power_quotient_ledger;
    outcome_t awaited_quotients[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Product of (q1*k + r1) and (q2*k + r2) kept as (quotient mod p, remainder mod k)
    static function void combine_pairs(input bit [63:0] q1, r1, q2, r2, k, p,
                                       output bit [63:0] qn, rn);
      bit [63:0] prod;
      bit [63:0] hi;
      prod = r1 * r2;
      hi   = (k % p) * q1 % p * q2 % p;
      qn   = (hi + r1 * q2 % p + r2 * q1 % p + (prod / k) % p) % p;
      rn   = prod % k;
    endfunction

    // Square-and-multiply over the exponent bits, most significant first
    static function outcome_t floor_quotient_mod(input field_t x_in, y_in, k_in, p_in);
      bit [63:0] mask;
      bit [63:0] x, y, k, p;
      bit [63:0] bq, br, aq, ar, nq, nr;
      int        top;
      outcome_t  res;
      mask = (64'd1 << ARITH_W) - 64'd1;
      x = x_in & mask;
      y = y_in & mask;
      k = k_in & mask;
      p = p_in & mask;
      res.bad  = 1'b0;
      res.quot = '0;
      if (k == 0 || p == 0) begin
        res.bad = 1'b1;
        return res;
      end
      if (y == 0) begin
        res.quot = (k == 1) ? field_t'(64'd1 % p) : '0;
        return res;
      end
      bq = (x / k) % p;
      br = x % k;
      top = 0;
      for (int i = 0; i < ARITH_W; i++) begin
        if (y[i]) top = i;
      end
      aq = bq;
      ar = br;
      for (int i = top - 1; i >= 0; i--) begin
        combine_pairs(aq, ar, aq, ar, k, p, nq, nr);
        aq = nq;
        ar = nr;
        if (y[i]) begin
          combine_pairs(aq, ar, bq, br, k, p, nq, nr);
          aq = nq;
          ar = nr;
        end
      end
      res.quot = field_t'(aq % p);
      return res;
    endfunction

    function void note_request(input field_t x, y, k, p);
      awaited_quotients.insert(awaited_quotients.size(), floor_quotient_mod(x, y, k, p));
    endfunction

    function void check_result(input field_t quot, input logic bad);
      outcome_t want;
      if (awaited_quotients.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("unexpected result: quotient_mod=%0d bad_operand=%0b", quot, bad);
        return;
      end
      want = awaited_quotients.pop_front();
      if (want.quot !== quot || want.bad !== bad) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("mismatch: expected quotient_mod=%0d bad_operand=%0b, got %0d %0b",
                   want.quot, want.bad, quot, bad);
      end
    endfunction

    function int outstanding();
      return awaited_quotients.size();
    endfunction
  endclass

  logic   clk_i        = 1'b0;
  logic   rst_ni       = 1'b0;
  logic   in_valid_i   = 1'b0;
  logic   in_stall_o;
  field_t base_value_i = '0;
  field_t exponent_i   = '0;
  field_t divisor_i    = '0;
  field_t modulus_i    = '0;
  logic   out_valid_o;
  logic   out_stall_i  = 1'b0;
  field_t quotient_mod_o;
  logic   bad_operand_o;

  power_quotient_ledger ledger = new();
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  longint cycles         = 0;

  power_floor_quotient_mod_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .base_value_i   (base_value_i),
    .exponent_i     (exponent_i),
    .divisor_i      (divisor_i),
    .modulus_i      (modulus_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .quotient_mod_o (quotient_mod_o),
    .bad_operand_o  (bad_operand_o)
  );

  always #5 clk_i = ~clk_i;

  // Result side: check accepted results, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      ledger.check_result(quotient_mod_o, bad_operand_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("power_floor_quotient_mod_core_tb: FAIL");
      $finish;
    end
  end

  // Present one request, idling first at random, and hold it until taken
  task automatic send_request(input field_t x, y, k, p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    base_value_i <= x;
    exponent_i   <= y;
    divisor_i    <= k;
    modulus_i    <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.note_request(x, y, k, p);
  endtask

  // Sender holds off until every outstanding result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.outstanding() != 0) @(posedge clk_i);
  endtask

  // Mostly short exponents keep the run length down; a few span the full width
  function automatic field_t pick_exponent();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5)  return '0;
    if (sel < 75) return field_t'($urandom_range(63, 1));
    if (sel < 90) return field_t'($urandom_range(4095, 64));
    return field_t'($urandom);
  endfunction

  function automatic field_t pick_divisor();
    int sel;
    sel = $urandom_range(99);
    if (sel < 3)  return '0;
    if (sel < 23) return field_t'(1);
    if (sel < 55) return field_t'($urandom_range(100, 2));
    return field_t'($urandom);
  endfunction

  function automatic field_t pick_modulus();
    int sel;
    sel = $urandom_range(99);
    if (sel < 3)  return '0;
    if (sel < 13) return field_t'(1);
    if (sel < 43) return field_t'($urandom_range(1000, 2));
    return field_t'($urandom);
  endfunction

  task automatic send_random_batch(input int count);
    field_t x, y, k, p;
    int     sel;
    for (int n = 0; n < count; n++) begin
      y = pick_exponent();
      k = pick_divisor();
      p = pick_modulus();
      sel = $urandom_range(99);
      if (sel < 20)      x = field_t'($urandom_range(20));
      else if (sel < 35) x = k + field_t'($urandom_range(2)) - field_t'(1);
      else               x = field_t'($urandom);
      send_request(x, y, k, p);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: error operands, zero exponent, modulus of one, field extremes
    send_request(32'd123, 32'd45, 32'd0, 32'd77);
    send_request(32'd9, 32'd3, 32'd10, 32'd0);
    send_request(32'd0, 32'd0, 32'd0, 32'd0);
    send_request(ALL_ONES, 32'd0, 32'd0, ALL_ONES);
    send_request(ALL_ONES, 32'd0, 32'd1, 32'd7);
    send_request(32'd5, 32'd0, 32'd1, 32'd1);
    send_request(32'd5, 32'd0, 32'd9, ALL_ONES);
    send_request(32'd0, 32'd0, 32'd1, 32'd1);
    send_request(ALL_ONES, ALL_ONES, ALL_ONES, 32'd1);
    send_request(32'd0, 32'd5, 32'd3, 32'd11);
    send_request(32'd1, ALL_ONES, 32'd1, ALL_ONES);
    send_request(ALL_ONES, ALL_ONES, 32'd1, ALL_ONES);
    send_request(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(ALL_ONES, 32'd1, ALL_ONES, ALL_ONES);
    send_request(ALL_ONES, 32'd2, 32'hFFFF_FFFE, 32'h8000_0000);
    send_request(32'd2, 32'd31, 32'd1, 32'h8000_0000);
    send_request(32'd3, 32'd40, 32'd1000, 32'hFFFF_FFFB);
    send_request(32'd2, 32'd10, ALL_ONES, 32'd1000);
    send_request(32'd12, 32'd1, 32'd12, 32'd5);
    send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC);
    send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 32'h3333_3333);
    drain_results();

    // Random phases with different idling on each side
    send_random_batch(67);
    drain_results();
    send_idle_pct = 79;
    send_random_batch(66);
    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 79;
    send_random_batch(66);
    drain_results();
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    send_random_batch(66);
    in_valid_i <= 1'b0;

    // Let the last results through, then a short tail for strays
    while (ledger.outstanding() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (ledger.mismatches == 0) begin
      $display("power_floor_quotient_mod_core_tb: PASS");
    end else begin
      $display("power_floor_quotient_mod_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pfqm_pkg.sv
design/power_floor_quotient_mod_core.sv
sim/power_floor_quotient_mod_core_tb.sv
